FILE: design/gcv_pkg.sv
`timescale 1ns / 1ps

package gcv_pkg;

  // Field widths.
  localparam int COEF_W     = 32;
  localparam int SAMPLE_W   = 32;
  localparam int VAR_W      = 48;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * COEF_W;
  localparam int HI_W       = VAR_W - COEF_W;

  // Delay line depth, independent of the configured orders.
  localparam int TAPS       = 3;
  localparam int HIST_IDX_W = 2;

  // Configuration port.
  localparam int CFG_ADDR_W = 3;
  localparam logic [CFG_ADDR_W-1:0] CFG_CONST_TERM = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_ARCH_1     = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_ARCH_2     = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_ARCH_3     = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_GARCH_1    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] CFG_GARCH_2    = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] CFG_GARCH_3    = 3'd6;

  localparam logic [VAR_W-1:0] VAR_MAX = {VAR_W{1'b1}};

  // Operations of the shared multiplier.
  typedef enum logic [1:0] {
    MAC_SQUARE,
    MAC_LO,
    MAC_HI
  } mac_op_t;

  // Control from the sequencer to the arithmetic unit.
  typedef struct packed {
    logic    clear;
    logic    issue;
    mac_op_t op;
  } mac_ctrl_t;

endpackage

FILE: design/gcv_in_if.sv
`timescale 1ns / 1ps

interface gcv_in_if;
  import gcv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       series_start;

  modport source (output valid, output sample, output series_start, input ready);
  modport sink   (input valid, input sample, input series_start, output ready);
endinterface

FILE: design/gcv_out_if.sv
`timescale 1ns / 1ps

interface gcv_out_if;
  import gcv_pkg::*;

  logic             valid;
  logic             ready;
  logic [VAR_W-1:0] variance;
  logic             saturated;

  modport source (output valid, output variance, output saturated, input ready);
  modport sink   (input valid, input variance, input saturated, output ready);
endinterface

FILE: design/gcv_mac_unit.sv
`timescale 1ns / 1ps

module gcv_mac_unit import gcv_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  mac_ctrl_t         ctrl,
  input  logic [COEF_W-1:0] op_a,
  input  logic [COEF_W-1:0] op_b,
  input  logic [COEF_W-1:0] init_val,
  output logic [VAR_W-1:0]  result,
  output logic              result_sat,
  output logic [VAR_W-1:0]  square
);

  logic [PROD_W-1:0] prod_r;
  logic              prod_vld_r;
  mac_op_t           prod_op_r;
  logic [VAR_W-1:0]  part_r;
  logic [VAR_W-1:0]  square_r;
  logic [VAR_W-1:0]  term_r;
  logic              term_ovf_r;
  logic              term_vld_r;
  logic [VAR_W-1:0]  acc_r;
  logic              sat_r;

  logic [PROD_W:0]   term_full;
  logic [VAR_W:0]    acc_sum;

  // High partial product shifted into place plus the truncated low part.
  assign term_full = {1'b0, prod_r[VAR_W-1:0], {FRAC_W{1'b0}}} + {17'd0, part_r};
  assign acc_sum   = {1'b0, acc_r} + {1'b0, term_r};

  // Stage valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_vld_r <= 1'b0;
      term_vld_r <= 1'b0;
    end else begin
      prod_vld_r <= ctrl.issue;
      term_vld_r <= prod_vld_r && (prod_op_r == MAC_HI);
    end
  end

  // Multiplier, partial product combine and accumulator.
  always_ff @(posedge clk) begin
    prod_r    <= op_a * op_b;
    prod_op_r <= ctrl.op;

    if (prod_vld_r) begin
      unique case (prod_op_r)
        MAC_SQUARE: square_r <= prod_r[PROD_W-1:FRAC_W];
        MAC_LO:     part_r   <= prod_r[PROD_W-1:FRAC_W];
        MAC_HI: begin
          term_r     <= term_full[VAR_W-1:0];
          term_ovf_r <= |term_full[PROD_W:VAR_W];
        end
        default: ;
      endcase
    end

    if (ctrl.clear) begin
      acc_r <= {{HI_W{1'b0}}, init_val};
      sat_r <= 1'b0;
    end else if (term_vld_r) begin
      acc_r <= acc_sum[VAR_W-1:0];
      sat_r <= sat_r | term_ovf_r | acc_sum[VAR_W];
    end
  end

  assign result     = sat_r ? VAR_MAX : acc_r;
  assign result_sat = sat_r;
  assign square     = square_r;

endmodule

FILE: design/garch_conditional_variance_core.sv
`timescale 1ns / 1ps
// Each input beat is worked in order: the sample square, then a low and a high partial
// product per ARCH tap and per GARCH tap, through the product, combine and accumulator registers.
// The finish state then loads the output register. A new input beat is taken only in the idle state,
// so a new sample is not accepted before the last one is through. The single 32x32 multiplier takes
// the sample square and two partial products per tap in turn.
// Reset (rst_n low, synchronous) clears the sequencer, the coefficients and both delay lines.

module garch_conditional_variance_core import gcv_pkg::*; #(
  parameter int ARCH_ORDER  = 3,
  parameter int GARCH_ORDER = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  gcv_in_if.sink                in_ch,
  gcv_out_if.source             out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [COEF_W-1:0]     cfg_wdata
);

  localparam int NUM_OPS = 1 + 2 * (ARCH_ORDER + GARCH_ORDER);
  localparam int OP_W    = $clog2(NUM_OPS);
  localparam logic [OP_W-1:0] LAST_OP = OP_W'(NUM_OPS - 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DRAIN,
    S_FINISH
  } state_t;

  state_t            state_r;
  logic [OP_W-1:0]   op_r;
  logic              drain_r;
  logic [COEF_W-1:0] sample_r;
  logic              out_valid_r;
  logic [VAR_W-1:0]  out_var_r;
  logic              out_sat_r;
  logic [VAR_W-1:0]  sq_hist_r  [TAPS];
  logic [VAR_W-1:0]  var_hist_r [TAPS];

  logic [COEF_W-1:0] const_r;
  logic [COEF_W-1:0] arch_r  [TAPS];
  logic [COEF_W-1:0] garch_r [TAPS];

  mac_ctrl_t         ctrl;
  logic [COEF_W-1:0] op_a;
  logic [COEF_W-1:0] op_b;
  logic [VAR_W-1:0]  mac_result;
  logic              mac_sat;
  logic [VAR_W-1:0]  mac_square;
  logic              in_fire;
  logic              out_free;

  assign in_ch.ready     = (state_r == S_IDLE);
  assign in_fire         = in_ch.valid && in_ch.ready;
  assign out_free        = !out_valid_r || out_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.variance = out_var_r;
  assign out_ch.saturated = out_sat_r;

  // Configuration registers; an index past the last register is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      const_r <= '0;
      for (int i = 0; i < TAPS; i++) begin
        arch_r[i]  <= '0;
        garch_r[i] <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_CONST_TERM: const_r    <= cfg_wdata;
        CFG_ARCH_1:     arch_r[0]  <= cfg_wdata;
        CFG_ARCH_2:     arch_r[1]  <= cfg_wdata;
        CFG_ARCH_3:     arch_r[2]  <= cfg_wdata;
        CFG_GARCH_1:    garch_r[0] <= cfg_wdata;
        CFG_GARCH_2:    garch_r[1] <= cfg_wdata;
        CFG_GARCH_3:    garch_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Operand selection: op 0 squares the sample, then a low and a high
  // partial product for each ARCH tap followed by each GARCH tap.
  always_comb begin
    logic [OP_W-1:0]       t;
    logic [OP_W-1:0]       tap;
    logic [OP_W-1:0]       sel;
    logic [HIST_IDX_W-1:0] idx;
    logic                  is_garch;
    logic [VAR_W-1:0]      val;
    logic [COEF_W-1:0]     mag;

    t        = op_r - OP_W'(1);
    tap      = t >> 1;
    is_garch = (tap >= OP_W'(ARCH_ORDER));
    sel      = is_garch ? (tap - OP_W'(ARCH_ORDER)) : tap;
    idx      = sel[HIST_IDX_W-1:0];
    val      = is_garch ? var_hist_r[idx] : sq_hist_r[idx];
    mag      = sample_r[COEF_W-1] ? (~sample_r + COEF_W'(1)) : sample_r;

    ctrl.clear = in_fire;
    ctrl.issue = (state_r == S_RUN);

    if (op_r == '0) begin
      ctrl.op = MAC_SQUARE;
      op_a    = mag;
      op_b    = mag;
    end else begin
      ctrl.op = t[0] ? MAC_HI : MAC_LO;
      op_a    = is_garch ? garch_r[idx] : arch_r[idx];
      op_b    = t[0] ? {{(COEF_W-HI_W){1'b0}}, val[VAR_W-1:COEF_W]} : val[COEF_W-1:0];
    end
  end

  gcv_mac_unit u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .op_a       (op_a),
    .op_b       (op_b),
    .init_val   (const_r),
    .result     (mac_result),
    .result_sat (mac_sat),
    .square     (mac_square)
  );

  // Sequencer, delay lines and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= '0;
      drain_r     <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < TAPS; i++) begin
        sq_hist_r[i]  <= '0;
        var_hist_r[i] <= '0;
      end
    end else begin
      // The finish state loads the output register itself.
      if (out_valid_r && out_ch.ready && (state_r != S_FINISH)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_fire) begin
            sample_r <= in_ch.sample;
            op_r     <= '0;
            state_r  <= S_RUN;
            // A new series starts with empty history.
            if (in_ch.series_start) begin
              for (int i = 0; i < TAPS; i++) begin
                sq_hist_r[i]  <= '0;
                var_hist_r[i] <= '0;
              end
            end
          end
        end
        S_RUN: begin
          if (op_r == LAST_OP) begin
            drain_r <= 1'b0;
            state_r <= S_DRAIN;
          end else begin
            op_r <= op_r + OP_W'(1);
          end
        end
        S_DRAIN: begin
          // Wait for the last product to pass the combine register and reach the accumulator.
          if (drain_r) begin
            state_r <= S_FINISH;
          end else begin
            drain_r <= 1'b1;
          end
        end
        S_FINISH: begin
          if (out_free) begin
            out_var_r   <= mac_result;
            out_sat_r   <= mac_sat;
            out_valid_r <= 1'b1;
            for (int i = TAPS - 1; i > 0; i--) begin
              sq_hist_r[i]  <= sq_hist_r[i-1];
              var_hist_r[i] <= var_hist_r[i-1];
            end
            sq_hist_r[0]  <= mac_square;
            var_hist_r[0] <= mac_result;
            state_r       <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import gcv_pkg::*;

  localparam int ARCH_ORDER   = 3;
  localparam int GARCH_ORDER  = 3;
  localparam int LATENCY      = 2 * (ARCH_ORDER + GARCH_ORDER) + 4;
  localparam int DRAIN_CYCLES = 2 * LATENCY;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 38;
  localparam int PHASE_ITEMS  = 95;
  localparam int PHASES       = 16;
  localparam int NO_IDLE_PHASE = 5;

  // Index with no register behind it; writes to it must be dropped.
  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MAX = {COEF_W{1'b1}};

  typedef struct packed {
    logic [VAR_W-1:0] variance;
    logic             saturated;
  } variance_t;

  typedef enum int {
    SET_STATIONARY,
    SET_WIDE,
    SET_MODEST,
    SET_ALL_MAX,
    SET_CONST_ONLY
  } setting_kind_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [COEF_W-1:0]     cfg_wdata;

  gcv_in_if  in_ch ();
  gcv_out_if out_ch ();

  garch_conditional_variance_core #(
    .ARCH_ORDER  (ARCH_ORDER),
    .GARCH_ORDER (GARCH_ORDER)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the coefficients and of both delay lines.
  logic [COEF_W-1:0] alpha0;
  logic [COEF_W-1:0] arch_weight  [TAPS];
  logic [COEF_W-1:0] garch_weight [TAPS];
  logic [VAR_W-1:0]  sq_line      [TAPS];
  logic [VAR_W-1:0]  var_line     [TAPS];

  variance_t expected_q[$];
  int        err_cnt     = 0;
  int        result_cnt  = 0;
  int        cycle_cnt   = 0;
  int        hold_left   = 0;
  bit        idle_on     = 1'b1;

  // Clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycle_cnt,
               expected_q.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("MISMATCH result %0d %s: got %h expected %h", result_cnt, what, got, want);
    err_cnt++;
  endtask

  // Coefficient times a Q32.16 value, floored to Q32.16; anything past 48 bits
  // comes back as 2^48 so that the sum clips.
  function automatic logic [63:0] weighted_tap(logic [COEF_W-1:0] c, logic [VAR_W-1:0] v);
    logic [COEF_W+VAR_W-1:0] p;
    p = ({{VAR_W{1'b0}}, c} * {{COEF_W{1'b0}}, v}) >> FRAC_W;
    if (p > VAR_MAX) return 64'(1) << VAR_W;
    return 64'(p[VAR_W-1:0]);
  endfunction

  // One GARCH step: forms h(t) from the history, then pushes y(t)^2 and h(t).
  function automatic variance_t next_variance(logic signed [SAMPLE_W-1:0] smp, logic start);
    logic [SAMPLE_W:0]     mag;
    logic [2*SAMPLE_W+1:0] sq_full;
    logic [VAR_W-1:0]      sq;
    logic [63:0]           acc;
    variance_t             res;
    mag = smp[SAMPLE_W-1] ? ({1'b1, {SAMPLE_W{1'b0}}} - {1'b0, smp}) : {1'b0, smp};
    sq_full = mag * mag;
    sq = sq_full[FRAC_W +: VAR_W];
    if (start) begin
      for (int i = 0; i < TAPS; i++) begin
        sq_line[i]  = '0;
        var_line[i] = '0;
      end
    end
    acc = 64'(alpha0);
    for (int i = 0; i < ARCH_ORDER && i < TAPS; i++)
      acc += weighted_tap(arch_weight[i], sq_line[i]);
    for (int i = 0; i < GARCH_ORDER && i < TAPS; i++)
      acc += weighted_tap(garch_weight[i], var_line[i]);
    if (acc > 64'(VAR_MAX)) begin
      res.variance  = VAR_MAX;
      res.saturated = 1'b1;
    end else begin
      res.variance  = acc[VAR_W-1:0];
      res.saturated = 1'b0;
    end
    for (int i = TAPS - 1; i > 0; i--) begin
      sq_line[i]  = sq_line[i-1];
      var_line[i] = var_line[i-1];
    end
    sq_line[0]  = sq;
    var_line[0] = res.variance;
    return res;
  endfunction

  // Register write, mirrored into the predictor.
  task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [COEF_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
    case (idx)
      CFG_CONST_TERM: alpha0          = val;
      CFG_ARCH_1:     arch_weight[0]  = val;
      CFG_ARCH_2:     arch_weight[1]  = val;
      CFG_ARCH_3:     arch_weight[2]  = val;
      CFG_GARCH_1:    garch_weight[0] = val;
      CFG_GARCH_2:    garch_weight[1] = val;
      CFG_GARCH_3:    garch_weight[2] = val;
      default: ;
    endcase
  endtask

  task automatic program_weights(logic [COEF_W-1:0] c, logic [COEF_W-1:0] a1,
                                 logic [COEF_W-1:0] a2, logic [COEF_W-1:0] a3,
                                 logic [COEF_W-1:0] g1, logic [COEF_W-1:0] g2,
                                 logic [COEF_W-1:0] g3);
    write_reg(CFG_CONST_TERM, c);
    write_reg(CFG_ARCH_1, a1);
    write_reg(CFG_ARCH_2, a2);
    write_reg(CFG_ARCH_3, a3);
    write_reg(CFG_GARCH_1, g1);
    write_reg(CFG_GARCH_2, g2);
    write_reg(CFG_GARCH_3, g3);
  endtask

  function automatic logic [COEF_W-1:0] rand_coef(setting_kind_t kind, bit is_garch);
    case (kind)
      SET_STATIONARY: return is_garch ? $urandom_range(0, 32'h0000_4CCC)
                                      : $urandom_range(0, 32'h0000_1999);
      SET_WIDE:       return $urandom;
      SET_MODEST:     return $urandom_range(0, 32'h0001_8000);
      SET_ALL_MAX:    return COEF_MAX;
      default:        return '0;
    endcase
  endfunction

  task automatic load_setting(setting_kind_t kind);
    logic [COEF_W-1:0] c;
    case (kind)
      SET_STATIONARY: c = $urandom_range(0, 32'h0000_0100);
      SET_MODEST:     c = $urandom_range(0, 32'h0010_0000);
      SET_ALL_MAX:    c = COEF_MAX;
      default:        c = $urandom;
    endcase
    program_weights(c, rand_coef(kind, 1'b0), rand_coef(kind, 1'b0), rand_coef(kind, 1'b0),
                    rand_coef(kind, 1'b1), rand_coef(kind, 1'b1), rand_coef(kind, 1'b1));
  endtask

  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      case ($urandom_range(0, 4))
        0:       return SAMPLE_MIN;
        1:       return SAMPLE_MAX;
        2:       return '0;
        3:       return '1;
        default: return 32'sd1;
      endcase
    end
    if (pick <= 3) return $urandom;
    // Typical returns of up to 25 percent either way.
    return SAMPLE_W'($signed($urandom_range(0, 32'h7FFF)) - 32'sh4000);
  endfunction

  // Offers one sample, holds it until accepted, and records its expected result.
  task automatic send_sample(logic signed [SAMPLE_W-1:0] smp, logic start);
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        in_ch.valid <= 1'b0;
      end else begin
        in_ch.valid        <= 1'b1;
        in_ch.sample       <= smp;
        in_ch.series_start <= start;
        break;
      end
    end
    forever begin
      @(posedge clk);
      if (in_ch.ready) break;
    end
    expected_q.push_back(next_variance(smp, start));
  endtask

  // Waits until every expected result has come and the pipeline is empty.
  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Result receiver: random stalls plus a counted hold-off on request.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Result checker.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        report_mismatch("unexpected beat, variance", 64'(out_ch.variance), '0);
      end else begin
        variance_t want;
        want = expected_q.pop_front();
        if (out_ch.variance !== want.variance)
          report_mismatch("variance", 64'(out_ch.variance), 64'(want.variance));
        if (out_ch.saturated !== want.saturated)
          report_mismatch("saturated", 64'(out_ch.saturated), 64'(want.saturated));
      end
      result_cnt++;
    end
  end

  // All coefficients zero after reset: every variance is zero.
  task automatic test_reset_defaults();
    send_sample(SAMPLE_MAX, 1'b1);
    send_sample(SAMPLE_MIN, 1'b0);
  endtask

  task automatic test_directed();
    // A write to the unused index must leave every register alone.
    wait_idle();
    write_reg(CFG_UNUSED, COEF_MAX);
    send_sample(32'sh0001_0000, 1'b0);

    // Typical weights, sample extremes, and a series restart mid-stream.
    wait_idle();
    program_weights(32'h0000_0100, 32'h0000_1999, 32'h0000_0CCC, 32'h0000_0666,
                    32'h0000_D999, 32'h0000_1000, 32'h0000_0800);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample('0, 1'b0);
    send_sample('1, 1'b0);
    send_sample(32'sd1, 1'b0);
    send_sample(32'sh0001_0000, 1'b0);
    send_sample(32'sh8000_0001, 1'b1);
    send_sample(-32'sh0001_0000, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);

    // Every weight at its maximum: products and sums clip, clipped values feed back.
    wait_idle();
    program_weights(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(SAMPLE_MIN, 1'b0);
    send_sample('0, 1'b0);
    send_sample(SAMPLE_MAX, 1'b0);
    send_sample(32'sd1, 1'b1);

    // Only the constant term.
    wait_idle();
    program_weights(COEF_MAX, '0, '0, '0, '0, '0, '0);
    send_sample(SAMPLE_MIN, 1'b1);
    send_sample(SAMPLE_MAX, 1'b0);
  endtask

  // The receiver holds off long enough for the block to fill and stall its input.
  task automatic test_backpressure();
    wait_idle();
    load_setting(SET_STATIONARY);
    idle_on   = 1'b0;
    hold_left = 400;
    send_sample(rand_sample(), 1'b1);
    for (int k = 1; k < 30; k++) send_sample(rand_sample(), 1'b0);
    idle_on = 1'b1;
  endtask

  // Random series under a sequence of weight settings.
  task automatic test_random_series();
    setting_kind_t kind;
    int            sent;
    int            len;
    logic          start;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      if (ph == 0) kind = SET_ALL_MAX;
      else if (ph == 1) kind = SET_CONST_ONLY;
      else kind = setting_kind_t'($urandom_range(0, 4));
      load_setting(kind);
      idle_on = (ph != NO_IDLE_PHASE);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        len = $urandom_range(1, 40);
        for (int k = 0; k < len && sent < PHASE_ITEMS; k++) begin
          start = (k == 0);
          // Occasional stray or missing series start.
          if ($urandom_range(0, 99) < 8) start = $urandom_range(0, 1);
          send_sample(rand_sample(), start);
          sent++;
        end
      end
    end
    idle_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < TAPS; i++) begin
      arch_weight[i]  = '0;
      garch_weight[i] = '0;
      sq_line[i]      = '0;
      var_line[i]     = '0;
    end
    alpha0             = '0;
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_addr           = '0;
    cfg_wdata          = '0;
    in_ch.valid        = 1'b0;
    in_ch.sample       = '0;
    in_ch.series_start = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_directed();
    test_backpressure();
    test_random_series();

    wait_idle();
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
